FILE: rtl/galois_ring_arithmetic_unit_top_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef GALOIS_RING_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define GALOIS_RING_ARITHMETIC_UNIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GRAU_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("grau same-cycle check failed");
`define GRAU_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("grau next-cycle check failed");
`else
`define GRAU_ASSERT_SAME(label, pre, post)
`define GRAU_ASSERT_NEXT(label, pre, post)
`endif
`endif

FILE: rtl/grau_pkg.sv
package grau_pkg;

  localparam int unsigned WORD_W         = 64;
  localparam int unsigned CVAL_W         = 8;
  localparam int unsigned DEG_W          = 4;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned STEP_BITS      = 4;
  localparam int unsigned APB_AW         = 5;
  localparam int unsigned APB_DW         = 64;
  localparam int unsigned MAX_DEGREE_DEF = 8;
  localparam int unsigned COEF_BITS_DEF  = 8;

  localparam logic [1:0] REG_CHAR = 2'd0;
  localparam logic [1:0] REG_DEG  = 2'd1;
  localparam logic [1:0] REG_MOD  = 2'd2;

  localparam logic [CVAL_W-1:0] CHAR_RST = 8'd2;
  localparam logic [DEG_W-1:0]  DEG_RST  = 4'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_NEG = 2'd2
  } op_t;

  // One restoring long-division step: shift in a bit, subtract c if it fits.
  function automatic logic [CVAL_W-1:0] mod_step(input logic [CVAL_W-1:0] rem,
                                                 input logic din,
                                                 input logic [CVAL_W-1:0] cmod);
    logic [CVAL_W:0] v;
    v = {rem, din};
    if (v >= {1'b0, cmod}) v = v - {1'b0, cmod};
    return v[CVAL_W-1:0];
  endfunction

endpackage

FILE: rtl/grau_modpipe.sv
module grau_modpipe #(
  parameter int unsigned W     = 8,
  parameter int unsigned LANES = 1,
  parameter int unsigned PW    = 1
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  logic [LANES-1:0][W-1:0]                  in_x,
  input  logic [grau_pkg::CVAL_W-1:0]              in_c,
  input  logic [PW-1:0]                            in_pay,
  output logic                                     out_valid,
  output logic [LANES-1:0][grau_pkg::CVAL_W-1:0]   out_r,
  output logic [PW-1:0]                            out_pay
);

  localparam int unsigned S   = grau_pkg::STEP_BITS;
  localparam int unsigned NST = (W + S - 1) / S;
  localparam int unsigned CW  = grau_pkg::CVAL_W;

  logic                          valid_r [NST];
  logic [LANES-1:0][W-1:0]       x_r     [NST];
  logic [LANES-1:0][CW-1:0]      rem_r   [NST];
  logic [CW-1:0]                 c_r     [NST];
  logic [PW-1:0]                 pay_r   [NST];

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic                     v_in;
    logic [LANES-1:0][W-1:0]  x_in;
    logic [LANES-1:0][CW-1:0] rem_in;
    logic [CW-1:0]            c_in;
    logic [PW-1:0]            pay_in;
    logic [LANES-1:0][CW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign x_in   = in_x;
      assign rem_in = '0;
      assign c_in   = in_c;
      assign pay_in = in_pay;
    end else begin : g_next
      assign v_in   = valid_r[k-1];
      assign x_in   = x_r[k-1];
      assign rem_in = rem_r[k-1];
      assign c_in   = c_r[k-1];
      assign pay_in = pay_r[k-1];
    end

    // S dividend bits per stage, MSB first
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [CW-1:0] chain [S+1];
      assign chain[0] = rem_in[l];
      for (genvar t = 0; t < S; t++) begin : g_bit
        localparam int B = int'(W) - 1 - int'(S * k + t);
        if (B >= 0) begin : g_use
          assign chain[t+1] = grau_pkg::mod_step(chain[t], x_in[l][B], c_in);
        end else begin : g_pass
          assign chain[t+1] = chain[t];
        end
      end
      assign rem_nxt[l] = chain[S];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= x_in;
        rem_r[k] <= rem_nxt;
        c_r[k]   <= c_in;
        pay_r[k] <= pay_in;
      end
    end
  end

  assign out_valid = valid_r[NST-1];
  assign out_r     = rem_r[NST-1];
  assign out_pay   = pay_r[NST-1];

endmodule

FILE: rtl/galois_ring_arithmetic_unit_top.sv
// Galois ring arithmetic unit: add, multiply or negate elements of (Z/cZ)[x]/(m(x)).
// Input channel in_valid/in_ready carries opcode and two packed elements;
// result channel out_valid/out_ready carries one result element per item.
// The APB-style port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
// characteristic (0x00), degree (0x08) and modulus coefficients (0x10);
// write it only while no item is in flight.
// Throughput: one item per cycle while out_ready does not stall the pipeline.
// The pipeline holds the mod-c long-division units (4 bits a stage) and the
// MAX_DEGREE-1 serial reduction steps, each a division unit, a multiply and
// an add stage.
// Reset (rst_n low, synchronous) empties the pipeline and sets c=2, d=1,
// modulus coefficients 0.
// When out_ready is low while a result waits, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
`include "galois_ring_arithmetic_unit_top_macros.svh"

module galois_ring_arithmetic_unit_top #(
  parameter int unsigned MAX_DEGREE = grau_pkg::MAX_DEGREE_DEF,
  parameter int unsigned COEF_BITS  = grau_pkg::COEF_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [grau_pkg::OP_W-1:0]       in_opcode,
  input  logic [grau_pkg::WORD_W-1:0]     in_operand_a,
  input  logic [grau_pkg::WORD_W-1:0]     in_operand_b,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [grau_pkg::WORD_W-1:0]     out_result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [grau_pkg::APB_AW-1:0]     paddr,
  input  logic [grau_pkg::APB_DW-1:0]     pwdata,
  output logic [grau_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int unsigned M   = MAX_DEGREE;
  localparam int unsigned CB  = COEF_BITS;
  localparam int unsigned CW  = grau_pkg::CVAL_W;
  localparam int unsigned DW  = grau_pkg::DEG_W;
  localparam int unsigned WW  = grau_pkg::WORD_W;
  localparam int unsigned PRW = 2 * CW;
  localparam int unsigned NP  = 2 * M - 1;
  localparam int unsigned AW  = PRW + $clog2(2 * M);
  localparam int unsigned IW  = $clog2(3 * M) + 1;

  typedef struct packed {
    logic [grau_pkg::OP_W-1:0] op;
    logic [DW-1:0]             d;
    logic [CW-1:0]             c;
    logic                      zero;
  } ctl_t;

  typedef struct packed {
    ctl_t                      ctl;
    logic [WW-1:0]             early;
    logic [M-1:0][CW-1:0]      negm;
    logic [NP-1:0][AW-1:0]     acc;
  } red_t;

  typedef struct packed {
    ctl_t          ctl;
    logic [WW-1:0] early;
  } fin_t;

  logic en;

  // ---------------- configuration ----------------
  logic [CW-1:0] cfg_char_r;
  logic [DW-1:0] cfg_deg_r;
  logic [WW-1:0] cfg_mod_r;
  logic [1:0]    reg_idx;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[grau_pkg::APB_AW-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_char_r <= grau_pkg::CHAR_RST;
      cfg_deg_r  <= grau_pkg::DEG_RST;
      cfg_mod_r  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        grau_pkg::REG_CHAR: cfg_char_r <= pwdata[CW-1:0];
        grau_pkg::REG_DEG:  cfg_deg_r  <= pwdata[DW-1:0];
        grau_pkg::REG_MOD:  cfg_mod_r  <= pwdata[WW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      grau_pkg::REG_CHAR: prdata = grau_pkg::APB_DW'(cfg_char_r);
      grau_pkg::REG_DEG:  prdata = grau_pkg::APB_DW'(cfg_deg_r);
      grau_pkg::REG_MOD:  prdata = grau_pkg::APB_DW'(cfg_mod_r);
      default:            prdata = '0;
    endcase
  end

  // ---------------- input stage ----------------
  logic          s0_v_r;
  ctl_t          s0_ctl_r;
  logic [WW-1:0] s0_a_r, s0_b_r, s0_m_r;
  ctl_t          ctl_in;

  always_comb begin
    ctl_in.op = in_opcode;
    ctl_in.c  = cfg_char_r;
    if (cfg_deg_r == '0) ctl_in.d = DW'(1);
    else if (cfg_deg_r > DW'(M)) ctl_in.d = DW'(M);
    else ctl_in.d = cfg_deg_r;
    ctl_in.zero = (cfg_char_r < CW'(2)) ||
                  !(in_opcode inside {grau_pkg::OP_ADD, grau_pkg::OP_MUL,
                                      grau_pkg::OP_NEG});
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ctl_r <= ctl_in;
      s0_a_r   <= in_operand_a;
      s0_b_r   <= in_operand_b;
      s0_m_r   <= cfg_mod_r;
    end
  end

  // ---------------- operand reduction mod c ----------------
  logic [3*M-1:0][CB-1:0] raw_x;
  logic                   ma_v;
  logic [3*M-1:0][CW-1:0] ma_r;
  logic [$bits(ctl_t)-1:0] ma_pay;

  for (genvar i = 0; i < M; i++) begin : g_unpack
    if (CB * i < WW) begin : g_in
      assign raw_x[i]       = CB'(s0_a_r >> (CB * i));
      assign raw_x[M + i]   = CB'(s0_b_r >> (CB * i));
      assign raw_x[2*M + i] = CB'(s0_m_r >> (CB * i));
    end else begin : g_out
      assign raw_x[i]       = '0;
      assign raw_x[M + i]   = '0;
      assign raw_x[2*M + i] = '0;
    end
  end

  grau_modpipe #(.W(CB), .LANES(3 * M), .PW($bits(ctl_t))) u_mod_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_v_r),
    .in_x      (raw_x),
    .in_c      (s0_ctl_r.c),
    .in_pay    (s0_ctl_r),
    .out_valid (ma_v),
    .out_r     (ma_r),
    .out_pay   (ma_pay)
  );

  // ---------------- add / negate / partial products ----------------
  ctl_t                          ma_ctl;
  logic [M-1:0][CW-1:0]          ra_m, rb_m, negm_nxt;
  logic [M-1:0][M-1:0][PRW-1:0]  prod_nxt;
  logic [WW-1:0]                 early_nxt;
  logic [CW:0]                   sum_tmp;
  logic [CW-1:0]                 lane_v;

  logic                          p_v_r;
  ctl_t                          p_ctl_r;
  logic [WW-1:0]                 p_early_r;
  logic [M-1:0][CW-1:0]          p_negm_r;
  logic [M-1:0][M-1:0][PRW-1:0]  p_prod_r;

  assign ma_ctl = ctl_t'(ma_pay);

  always_comb begin
    early_nxt = '0;
    sum_tmp   = '0;
    lane_v    = '0;
    for (int i = 0; i < M; i++) begin
      if (DW'(i) < ma_ctl.d) begin
        ra_m[i] = ma_r[i];
        rb_m[i] = ma_r[M + i];
      end else begin
        ra_m[i] = '0;
        rb_m[i] = '0;
      end
      negm_nxt[i] = (ma_r[2*M + i] != '0) ? ma_ctl.c - ma_r[2*M + i] : '0;
      sum_tmp = {1'b0, ra_m[i]} + {1'b0, rb_m[i]};
      if (sum_tmp >= {1'b0, ma_ctl.c}) sum_tmp = sum_tmp - {1'b0, ma_ctl.c};
      if (ma_ctl.op == grau_pkg::OP_NEG) begin
        lane_v = (ra_m[i] != '0) ? ma_ctl.c - ra_m[i] : '0;
      end else begin
        lane_v = sum_tmp[CW-1:0];
      end
      if (CB * i < WW) begin
        early_nxt = early_nxt | (WW'(CB'(lane_v)) << (CB * i));
      end
    end
    for (int i = 0; i < M; i++) begin
      for (int j = 0; j < M; j++) begin
        prod_nxt[i][j] = PRW'(ra_m[i]) * PRW'(rb_m[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= ma_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ctl_r   <= ma_ctl;
      p_early_r <= early_nxt;
      p_negm_r  <= negm_nxt;
      p_prod_r  <= prod_nxt;
    end
  end

  // ---------------- convolution sums ----------------
  logic [NP-1:0][AW-1:0] acc_nxt;
  logic                  s_v_r;
  red_t                  s_pay_r;

  always_comb begin
    acc_nxt = '0;
    for (int i = 0; i < M; i++) begin
      for (int j = 0; j < M; j++) begin
        acc_nxt[i + j] = acc_nxt[i + j] + AW'(p_prod_r[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (en) begin
      s_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_pay_r.ctl   <= p_ctl_r;
      s_pay_r.early <= p_early_r;
      s_pay_r.negm  <= p_negm_r;
      s_pay_r.acc   <= acc_nxt;
    end
  end

  // ---------------- serial reduction by the monic modulus ----------------
  // Step s folds the term x^(2d-2-s) back through x^d = -(m(d-1)x^(d-1)+...+m0).
  logic rv [M];
  red_t rp [M];

  assign rv[0] = s_v_r;
  assign rp[0] = s_pay_r;

  for (genvar s = 0; s + 1 < M; s++) begin : g_red
    localparam int unsigned AXW = (NP > 1) ? $clog2(NP) : 1;

    logic                  act_in, act_m;
    logic [IW-1:0]         idx_in, idx_m, base_m;
    logic [AW-1:0]         t_x;
    logic                  md_v;
    logic [0:0][CW-1:0]    md_t;
    logic [$bits(red_t)-1:0] md_pay;
    red_t                  md_red, mul_pay_nxt, add_pay_nxt;
    logic [M-1:0][PRW-1:0] tn_nxt;

    logic                  mul_v_r;
    red_t                  mul_pay_r;
    logic [M-1:0][PRW-1:0] mul_tn_r;
    logic                  add_v_r;
    red_t                  add_pay_r;

    always_comb begin
      act_in = IW'(rp[s].ctl.d) >= IW'(s + 2);
      idx_in = (IW'(rp[s].ctl.d) << 1) - IW'(s + 2);
      t_x    = act_in ? rp[s].acc[idx_in[AXW-1:0]] : '0;
    end

    grau_modpipe #(.W(AW), .LANES(1), .PW($bits(red_t))) u_mod_red (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (rv[s]),
      .in_x      (t_x),
      .in_c      (rp[s].ctl.c),
      .in_pay    (rp[s]),
      .out_valid (md_v),
      .out_r     (md_t),
      .out_pay   (md_pay)
    );

    always_comb begin
      md_red      = red_t'(md_pay);
      mul_pay_nxt = md_red;
      act_m       = IW'(md_red.ctl.d) >= IW'(s + 2);
      idx_m       = (IW'(md_red.ctl.d) << 1) - IW'(s + 2);
      if (act_m) mul_pay_nxt.acc[idx_m[AXW-1:0]] = '0;
      for (int j = 0; j < M; j++) begin
        tn_nxt[j] = act_m ? PRW'(md_t[0]) * PRW'(md_red.negm[j]) : '0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mul_v_r <= 1'b0;
        add_v_r <= 1'b0;
      end else if (en) begin
        mul_v_r <= md_v;
        add_v_r <= mul_v_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mul_pay_r <= mul_pay_nxt;
        mul_tn_r  <= tn_nxt;
        add_pay_r <= add_pay_nxt;
      end
    end

    // tn[j] lands on coefficient (i - d + j); tn is zero on idle steps
    always_comb begin
      add_pay_nxt = mul_pay_r;
      base_m      = (IW'(mul_pay_r.ctl.d) << 1) - IW'(s + 2) - IW'(mul_pay_r.ctl.d);
      for (int p = 0; p < NP; p++) begin
        for (int j = 0; j < M; j++) begin
          if ((IW'(p) == base_m + IW'(j)) && (IW'(j) < IW'(mul_pay_r.ctl.d))) begin
            add_pay_nxt.acc[p] = add_pay_nxt.acc[p] + AW'(mul_tn_r[j]);
          end
        end
      end
    end

    assign rv[s+1] = add_v_r;
    assign rp[s+1] = add_pay_r;
  end

  // ---------------- final reduction and result ----------------
  logic [M-1:0][AW-1:0]     fin_x;
  fin_t                     fin_in;
  logic                     fd_v;
  logic [M-1:0][CW-1:0]     fd_r;
  logic [$bits(fin_t)-1:0]  fd_pay;
  fin_t                     fd_fin;
  logic [WW-1:0]            result_nxt;
  logic [WW-1:0]            mul_word;
  logic                     out_valid_r;
  logic [WW-1:0]            out_result_r;

  always_comb begin
    for (int i = 0; i < M; i++) fin_x[i] = rp[M-1].acc[i];
    fin_in.ctl   = rp[M-1].ctl;
    fin_in.early = rp[M-1].early;
  end

  grau_modpipe #(.W(AW), .LANES(M), .PW($bits(fin_t))) u_mod_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rv[M-1]),
    .in_x      (fin_x),
    .in_c      (rp[M-1].ctl.c),
    .in_pay    (fin_in),
    .out_valid (fd_v),
    .out_r     (fd_r),
    .out_pay   (fd_pay)
  );

  always_comb begin
    fd_fin   = fin_t'(fd_pay);
    mul_word = '0;
    for (int i = 0; i < M; i++) begin
      if ((CB * i < WW) && (DW'(i) < fd_fin.ctl.d)) begin
        mul_word = mul_word | (WW'(CB'(fd_r[i])) << (CB * i));
      end
    end
    if (fd_fin.ctl.zero) result_nxt = '0;
    else if (fd_fin.ctl.op == grau_pkg::OP_MUL) result_nxt = mul_word;
    else result_nxt = fd_fin.early;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_r <= result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // ---------------- checks ----------------
  `GRAU_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, s0_v_r)
  `GRAU_ASSERT_NEXT(a_stall_freezes, !en, $stable(s0_v_r) && $stable(p_v_r) && $stable(s_v_r))
  `GRAU_ASSERT_SAME(a_ready_follows, out_valid_r && !out_ready, !in_ready)

endmodule
